/* rtl/tksd_pkg.sv */
package tksd_pkg;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_TIMEOUT = 2'd1,
        ACT_EOF     = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_OPEN = 3'd2,
        PH_N1   = 3'd3,
        PH_SEMI = 3'd4,
        PH_N2   = 3'd5
    } phase_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_SS3     = 8'h4F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CTRL_LO = 8'd1;
    localparam logic [7:0] CH_CTRL_HI = 8'd26;
    localparam logic [7:0] CH_LOWER_OFS = 8'd96;
    localparam logic [7:0] CH_TAB     = 8'd9;

    localparam logic [7:0] END_UP     = 8'h41;
    localparam logic [7:0] END_DOWN   = 8'h42;
    localparam logic [7:0] END_RIGHT  = 8'h43;
    localparam logic [7:0] END_LEFT   = 8'h44;
    localparam logic [7:0] END_HOME   = 8'h48;
    localparam logic [7:0] END_END    = 8'h46;
    localparam logic [7:0] END_BTAB   = 8'h5A;
    localparam logic [7:0] END_DEL    = 8'd3;
    localparam logic [7:0] END_PGUP   = 8'd5;
    localparam logic [7:0] END_PGDN   = 8'd6;

    localparam logic [8:0] KC_NONE  = 9'd0;
    localparam logic [8:0] KC_UP    = 9'd256;
    localparam logic [8:0] KC_DOWN  = 9'd257;
    localparam logic [8:0] KC_RIGHT = 9'd258;
    localparam logic [8:0] KC_LEFT  = 9'd259;
    localparam logic [8:0] KC_HOME  = 9'd260;
    localparam logic [8:0] KC_END   = 9'd261;
    localparam logic [8:0] KC_DEL   = 9'd262;
    localparam logic [8:0] KC_PGUP  = 9'd263;
    localparam logic [8:0] KC_PGDN  = 9'd264;
    localparam logic [8:0] KC_EOF   = 9'd265;

    localparam logic [3:0] MOD_NONE  = 4'd0;
    localparam logic [3:0] MOD_SHIFT = 4'd1;
    localparam logic [3:0] MOD_CTRL  = 4'd4;
    localparam logic [3:0] NUM_ONE   = 4'd1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [8:0] key_code;
        logic [3:0] modifiers;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } dec_result_t;

    typedef struct packed {
        logic [8:0] code;
        logic [3:0] flag;
    } end_lookup_t;

    function automatic end_lookup_t end_lookup(logic [7:0] endv);
        end_lookup_t r;
        r.flag = MOD_NONE;
        unique case (endv)
            END_UP:    r.code = KC_UP;
            END_DOWN:  r.code = KC_DOWN;
            END_RIGHT: r.code = KC_RIGHT;
            END_LEFT:  r.code = KC_LEFT;
            END_HOME:  r.code = KC_HOME;
            END_END:   r.code = KC_END;
            END_BTAB:
            begin
                r.code = {1'b0, CH_TAB};
                r.flag = MOD_SHIFT;
            end
            END_DEL:   r.code = KC_DEL;
            END_PGUP:  r.code = KC_PGUP;
            END_PGDN:  r.code = KC_PGDN;
            default:   r.code = KC_NONE;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tksd_stream_if.sv */
interface tksd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/tksd_decoder.sv */
module tksd_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  tksd_pkg::in_item_t    item,
    output tksd_pkg::dec_result_t res
);

    tksd_pkg::phase_t phase_reg, phase_next;
    logic [3:0] n1_reg, n1_next;
    logic [3:0] n2_reg, n2_next;

    tksd_pkg::action_t  act;
    logic [7:0]         c;
    logic               eof;
    logic               digit_hit;
    logic [7:0]         endv;
    tksd_pkg::end_lookup_t hit;
    tksd_pkg::out_item_t   fin;
    tksd_pkg::out_item_t   res_item;
    logic                  res_valid;

    assign act       = tksd_pkg::action_t'(item.action);
    assign eof       = (act == tksd_pkg::ACT_EOF);
    assign c         = (act == tksd_pkg::ACT_TIMEOUT) ? tksd_pkg::CH_NUL : item.rx_byte;
    assign digit_hit = !eof && (c >= tksd_pkg::CH_DIGIT0) && (c <= tksd_pkg::CH_DIGIT9);
    assign endv      = (c == tksd_pkg::CH_TILDE) ? {4'b0000, n1_reg} : c;
    assign hit       = tksd_pkg::end_lookup(endv);

    // sequence end: modifiers from n2, table hit unless end of input
    always_comb
    begin
        fin.modifiers = 4'(n2_reg - tksd_pkg::NUM_ONE);
        fin.key_code  = tksd_pkg::KC_NONE;
        if (!eof)
        begin
            fin.key_code  = hit.code;
            fin.modifiers = fin.modifiers | hit.flag;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        if (act != tksd_pkg::ACT_NONE)
        begin
            unique case (phase_reg)
                tksd_pkg::PH_ESC:
                begin
                    if (!eof && (c == tksd_pkg::CH_LBRACK || c == tksd_pkg::CH_SS3))
                        phase_next = tksd_pkg::PH_OPEN;
                    else
                        phase_next = tksd_pkg::PH_IDLE;
                end
                tksd_pkg::PH_OPEN, tksd_pkg::PH_N1:
                begin
                    if (phase_reg == tksd_pkg::PH_OPEN && digit_hit)
                    begin
                        n1_next    = c[3:0];
                        phase_next = tksd_pkg::PH_N1;
                    end
                    else if (!eof && c == tksd_pkg::CH_SEMI)
                        phase_next = tksd_pkg::PH_SEMI;
                    else
                    begin
                        phase_next = tksd_pkg::PH_IDLE;
                        n1_next    = tksd_pkg::NUM_ONE;
                        n2_next    = tksd_pkg::NUM_ONE;
                    end
                end
                tksd_pkg::PH_SEMI:
                begin
                    if (digit_hit)
                    begin
                        n2_next    = c[3:0];
                        phase_next = tksd_pkg::PH_N2;
                    end
                    else
                    begin
                        phase_next = tksd_pkg::PH_IDLE;
                        n1_next    = tksd_pkg::NUM_ONE;
                        n2_next    = tksd_pkg::NUM_ONE;
                    end
                end
                tksd_pkg::PH_N2:
                begin
                    phase_next = tksd_pkg::PH_IDLE;
                    n1_next    = tksd_pkg::NUM_ONE;
                    n2_next    = tksd_pkg::NUM_ONE;
                end
                default:
                begin
                    n1_next = tksd_pkg::NUM_ONE;
                    n2_next = tksd_pkg::NUM_ONE;
                    if (act == tksd_pkg::ACT_BYTE && c == tksd_pkg::CH_ESC)
                        phase_next = tksd_pkg::PH_ESC;
                    else
                        phase_next = tksd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        res_valid = 1'b0;
        res_item  = '{key_code: tksd_pkg::KC_NONE, modifiers: tksd_pkg::MOD_NONE};
        if (act != tksd_pkg::ACT_NONE)
        begin
            unique case (phase_reg)
                tksd_pkg::PH_ESC:
                begin
                    if (eof)
                    begin
                        res_valid         = 1'b1;
                        res_item.key_code = tksd_pkg::KC_EOF;
                    end
                    else if (c != tksd_pkg::CH_LBRACK && c != tksd_pkg::CH_SS3)
                    begin
                        res_valid         = 1'b1;
                        res_item.key_code = (c == tksd_pkg::CH_NUL) ?
                                            {1'b0, tksd_pkg::CH_ESC} : {1'b0, c};
                    end
                end
                tksd_pkg::PH_OPEN, tksd_pkg::PH_N1:
                begin
                    if (!(phase_reg == tksd_pkg::PH_OPEN && digit_hit) &&
                        !(!eof && c == tksd_pkg::CH_SEMI))
                    begin
                        res_valid = 1'b1;
                        res_item  = fin;
                    end
                end
                tksd_pkg::PH_SEMI:
                begin
                    if (!digit_hit)
                    begin
                        res_valid = 1'b1;
                        res_item  = fin;
                    end
                end
                tksd_pkg::PH_N2:
                begin
                    res_valid = 1'b1;
                    res_item  = fin;
                end
                default:
                begin
                    if (eof)
                    begin
                        res_valid         = 1'b1;
                        res_item.key_code = tksd_pkg::KC_EOF;
                    end
                    else if (act == tksd_pkg::ACT_BYTE && c != tksd_pkg::CH_ESC)
                    begin
                        res_valid = 1'b1;
                        if (c >= tksd_pkg::CH_CTRL_LO && c <= tksd_pkg::CH_CTRL_HI)
                        begin
                            res_item.key_code  = {1'b0, 8'(c + tksd_pkg::CH_LOWER_OFS)};
                            res_item.modifiers = tksd_pkg::MOD_CTRL;
                        end
                        else if (c >= tksd_pkg::CH_UPPER_A && c <= tksd_pkg::CH_UPPER_Z)
                        begin
                            res_item.key_code  = {1'b0, c};
                            res_item.modifiers = tksd_pkg::MOD_SHIFT;
                        end
                        else
                            res_item.key_code = {1'b0, c};
                    end
                end
            endcase
        end
    end

    assign res.valid = fire && res_valid;
    assign res.item  = res_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tksd_pkg::PH_IDLE;
            n1_reg    <= tksd_pkg::NUM_ONE;
            n2_reg    <= tksd_pkg::NUM_ONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
        end
    end

    a_none_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && act == tksd_pkg::ACT_NONE |=> $stable(phase_reg) && $stable(n2_reg))
        else $error("ignored action changed parser state");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.item.key_code <= tksd_pkg::KC_EOF)
        else $error("key code out of range");

    a_n2_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == tksd_pkg::PH_N2 && act != tksd_pkg::ACT_NONE
        |-> res.valid ##1 phase_reg == tksd_pkg::PH_IDLE)
        else $error("sequence after n2 did not finish");

    a_eof_plain: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.item.key_code == tksd_pkg::KC_EOF
        |-> res.item.modifiers == tksd_pkg::MOD_NONE)
        else $error("end of input carries modifiers");

endmodule

/* rtl/tksd_out_stage.sv */
module tksd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tksd_pkg::dec_result_t res,
    output logic                  can_load,
    tksd_stream_if.source         key_out
);

    logic                valid_reg;
    tksd_pkg::out_item_t item_reg;

    assign can_load        = !valid_reg || key_out.ready;
    assign key_out.valid   = valid_reg;
    assign key_out.payload = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (can_load && res.valid)
            item_reg <= res.item;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !key_out.ready |=> valid_reg && $stable(item_reg))
        else $error("pending result lost");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !can_load |-> valid_reg)
        else $error("result offered while stage blocked without pending item");

    a_rise_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(res.valid))
        else $error("output valid without decoded result");

endmodule

/* rtl/terminal_key_sequence_decoder.sv */
// Terminal key sequence decoder.
// key_in carries terminal events (action, rx_byte): a received byte, a wait
// timeout or end of input. key_out carries decoded keys (key_code, modifiers).
// Both channels use valid/ready; a transfer happens when both are high.
// An event is captured in an input register, decoded by the escape parser
// once the output register can load and, if it produces a key, placed in the output register.
// The closing event passes the input register, and its key then the output
// register, before key_out.valid rises. key_in accepts one event per cycle
// while key_out does not stall, as the parser updates once per taken event.
// Events that continue an escape sequence, and timeouts while idle, produce no key.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to idle with both sequence numbers at one.
// When key_out stalls, the pending key holds; the parser stops and key_in
// takes one more event only if the input register is empty, then ready drops.
module terminal_key_sequence_decoder (
    input  logic          clk,
    input  logic          rst_n,
    tksd_stream_if.sink   key_in,
    tksd_stream_if.source key_out
);

    logic                  in_valid_reg;
    tksd_pkg::in_item_t    in_item_reg;
    logic                  can_load;
    logic                  fire;
    tksd_pkg::dec_result_t res;

    assign fire         = in_valid_reg && can_load;
    assign key_in.ready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (key_in.ready)
            in_valid_reg <= key_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (key_in.valid && key_in.ready)
            in_item_reg <= key_in.payload;
    end

    tksd_decoder u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .res   (res)
    );

    tksd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .can_load (can_load),
        .key_out  (key_out)
    );

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !can_load |=> in_valid_reg && $stable(in_item_reg))
        else $error("input event dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> key_in.ready)
        else $error("input not ready while empty");

    a_fire_consumes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !key_in.valid |=> !in_valid_reg)
        else $error("consumed event still marked valid");

endmodule
